[rtl/vq_pkg.sv]
// Package with the word types, codes and widths of the vector quantizer.
`default_nettype none

package vq_pkg;

    // Element value width and the widths of the search arithmetic.
    localparam int VALUE_BITS = 16;
    localparam int DIFF_BITS  = VALUE_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    // A sum of at most 31 squares needs five more bits.
    localparam int ACC_BITS   = SQ_BITS + 5;

    // Configuration register widths and defaults.
    localparam int COUNT_BITS = 9;
    localparam int LEN_BITS   = 5;
    localparam int CFG_BITS   = 9;
    localparam int CFG_INDEX_BITS = 1;
    localparam int COUNT_RESET = 256;
    localparam int LEN_RESET   = 16;

    // Storage defaults for the top-level parameters.
    localparam int MAX_CODEWORDS_DEF = 256;
    localparam int MAX_DIM_DEF       = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_CODEWORDS_IN_USE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VECTOR_LENGTH    = 1'd1;

    // Function codes of an input word.
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_ENCODE = 2'd1;
    localparam logic [1:0] FUNC_DECODE = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    typedef struct packed {
        logic [1:0]                   func;
        logic [7:0]                   code_index;
        logic [3:0]                   position;
        logic signed [VALUE_BITS-1:0] sample;
        logic                         final_element;
    } in_word_t;

    typedef struct packed {
        logic [7:0]                   found_index;
        logic signed [VALUE_BITS-1:0] element_out;
        logic                         status;
        logic                         last_result;
    } out_word_t;

endpackage

`default_nettype wire

[rtl/vector_quantizer_nearest_codeword_unit.sv]
// Vector quantizer: codebook store, nearest-codeword search and codeword readout.
// Write and non-final encode words leave the block idle; it is ready again at once.
// A final encode word searches all codewords in use and returns the nearest index;
// one shared subtract-square-accumulate pipe takes one element per cycle.
// Decode returns its elements one at a time, each read through the registered codebook.
// Reset clears control and sets the registers to 256 codewords of 16 elements; the
// codebook and query buffer hold no defined value until written, and need no clearing.
`default_nettype none

module vector_quantizer_nearest_codeword_unit #(
    parameter int MAX_CODEWORDS = vq_pkg::MAX_CODEWORDS_DEF,
    parameter int MAX_DIM       = vq_pkg::MAX_DIM_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_write,
    input  wire  [vq_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire  [vq_pkg::CFG_BITS-1:0]         cfg_data,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  vq_pkg::in_word_t              in_data,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output vq_pkg::out_word_t                   out_data
);

    localparam int VB      = vq_pkg::VALUE_BITS;
    localparam int DW      = vq_pkg::DIFF_BITS;
    localparam int SW      = vq_pkg::SQ_BITS;
    localparam int AW_ACC  = vq_pkg::ACC_BITS;
    localparam int CW      = vq_pkg::COUNT_BITS;
    localparam int LW      = vq_pkg::LEN_BITS;
    localparam int DEPTH   = MAX_CODEWORDS * MAX_DIM;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_RST = (MAX_CODEWORDS < vq_pkg::COUNT_RESET) ?
                             MAX_CODEWORDS : vq_pkg::COUNT_RESET;
    localparam int LEN_RST = (MAX_DIM < vq_pkg::LEN_RESET) ? MAX_DIM : vq_pkg::LEN_RESET;

    typedef enum logic [2:0] {
        IDLE,
        SRCH,
        SRCH_DRAIN,
        SRCH_OUT,
        DEC_ADDR,
        DEC_DATA,
        DEC_ERR
    } state_t;

    // Tag that travels with each element through the search pipe.
    typedef struct packed {
        logic          valid;
        logic          last_elem;
        logic          last_code;
        logic [CW-1:0] code;
    } tag_t;

    state_t state_reg, state_next;
    logic [CW-1:0]    code_reg, code_next;
    logic [DIM_W-1:0] elem_reg, elem_next;
    logic             out_valid_reg, out_valid_next;
    vq_pkg::out_word_t out_word_reg, out_word_next;
    logic [CW-1:0]    count_reg;
    logic [LW-1:0]    len_reg;

    logic signed [VB-1:0] codebook [DEPTH];
    logic signed [VB-1:0] query_buf [MAX_DIM];
    logic signed [VB-1:0] cb_rd_reg;
    logic signed [VB-1:0] q_rd_reg;

    tag_t tag1_reg, tag2_reg, tag3_reg, tag0;
    logic signed [DW-1:0]   diff_reg;
    logic signed [DW-1:0]   diff_next;
    logic signed [SW-1:0]   prod;
    logic [SW-1:0]          sq_reg;
    logic [AW_ACC-1:0]      acc_reg, best_dist_reg, sum;
    logic [CW-1:0]          best_reg;

    logic                   accept;
    logic                   slot_free;
    logic                   last_elem;
    logic                   last_code;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   cb_we;
    logic                   q_we;
    logic [CW-1:0]          cfg_count;
    logic [LW-1:0]          cfg_len;

    assign in_ready  = (state_reg == IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    assign last_elem = (32'(elem_reg) + 1) == 32'(len_reg);
    assign last_code = (32'(code_reg) + 1) == 32'(count_reg);

    // Configuration values are kept already limited to the storage.
    always_comb
    begin
        cfg_count = cfg_data[CW-1:0];
        if (cfg_data[CW-1:0] == '0)
        begin
            cfg_count = CW'(1);
        end
        else if (32'(cfg_data[CW-1:0]) > MAX_CODEWORDS)
        begin
            cfg_count = CW'(MAX_CODEWORDS);
        end
        cfg_len = cfg_data[LW-1:0];
        if (cfg_data[LW-1:0] == '0)
        begin
            cfg_len = LW'(1);
        end
        else if (32'(cfg_data[LW-1:0]) > MAX_DIM)
        begin
            cfg_len = LW'(MAX_DIM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(CNT_RST);
            len_reg   <= LW'(LEN_RST);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                vq_pkg::REG_CODEWORDS_IN_USE: count_reg <= cfg_count;
                vq_pkg::REG_VECTOR_LENGTH:    len_reg   <= cfg_len;
                default: ;
            endcase
        end
    end

    // Codebook and query buffer: one write and one registered read each.
    assign wr_addr = ADDR_W'(32'(in_data.code_index) * MAX_DIM + 32'(in_data.position));
    assign rd_addr = ADDR_W'(32'(code_reg) * MAX_DIM + 32'(elem_reg));
    assign cb_we   = accept && (in_data.func == vq_pkg::FUNC_WRITE)
                     && (32'(in_data.code_index) < MAX_CODEWORDS)
                     && (32'(in_data.position) < MAX_DIM);
    assign q_we    = accept && (in_data.func == vq_pkg::FUNC_ENCODE)
                     && (32'(in_data.position) < MAX_DIM);

    always_ff @(posedge clk)
    begin
        if (cb_we)
        begin
            codebook[wr_addr] <= in_data.sample;
        end
        cb_rd_reg <= codebook[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            query_buf[DIM_W'(in_data.position)] <= in_data.sample;
        end
        q_rd_reg <= query_buf[elem_reg];
    end

    // Search pipe: read, subtract, square, then accumulate and compare.
    always_comb
    begin
        tag0.valid     = (state_reg == SRCH);
        tag0.last_elem = last_elem;
        tag0.last_code = last_code;
        tag0.code      = code_reg;
    end

    assign diff_next = {q_rd_reg[VB-1], q_rd_reg} - {cb_rd_reg[VB-1], cb_rd_reg};
    assign prod      = diff_reg * diff_reg;
    assign sum       = acc_reg + AW_ACC'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            tag1_reg <= tag0;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            if (tag3_reg.valid)
            begin
                acc_reg <= tag3_reg.last_elem ? '0 : sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sq_reg   <= $unsigned(prod);
        // Strict compare keeps the lowest index on a tie.
        if (tag3_reg.valid && tag3_reg.last_elem
            && ((tag3_reg.code == '0) || (sum < best_dist_reg)))
        begin
            best_dist_reg <= sum;
            best_reg      <= tag3_reg.code;
        end
    end

    // Sequencer for search and readout, and the output word register.
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        elem_next      = elem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    case (in_data.func)
                        vq_pkg::FUNC_ENCODE:
                        begin
                            if (in_data.final_element)
                            begin
                                code_next  = '0;
                                elem_next  = '0;
                                state_next = SRCH;
                            end
                        end
                        vq_pkg::FUNC_DECODE:
                        begin
                            code_next = CW'(in_data.code_index);
                            elem_next = '0;
                            if (CW'(in_data.code_index) >= count_reg)
                            begin
                                state_next = DEC_ERR;
                            end
                            else
                            begin
                                state_next = DEC_ADDR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            SRCH:
            begin
                if (last_elem)
                begin
                    elem_next = '0;
                    if (last_code)
                    begin
                        state_next = SRCH_DRAIN;
                    end
                    else
                    begin
                        code_next = code_reg + CW'(1);
                    end
                end
                else
                begin
                    elem_next = elem_reg + DIM_W'(1);
                end
            end
            SRCH_DRAIN:
            begin
                if (tag3_reg.valid && tag3_reg.last_elem && tag3_reg.last_code)
                begin
                    state_next = SRCH_OUT;
                end
            end
            SRCH_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.found_index = best_reg[7:0];
                    out_word_next.element_out = '0;
                    out_word_next.status      = vq_pkg::STATUS_OK;
                    out_word_next.last_result = 1'b1;
                    state_next                = IDLE;
                end
            end
            DEC_ADDR:
            begin
                state_next = DEC_DATA;
            end
            DEC_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.found_index = code_reg[7:0];
                    out_word_next.element_out = cb_rd_reg;
                    out_word_next.status      = vq_pkg::STATUS_OK;
                    out_word_next.last_result = last_elem;
                    if (last_elem)
                    begin
                        state_next = IDLE;
                    end
                    else
                    begin
                        elem_next  = elem_reg + DIM_W'(1);
                        state_next = DEC_ADDR;
                    end
                end
            end
            DEC_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.found_index = code_reg[7:0];
                    out_word_next.element_out = '0;
                    out_word_next.status      = vq_pkg::STATUS_BAD_INDEX;
                    out_word_next.last_result = 1'b1;
                    state_next                = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            code_reg      <= '0;
            elem_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            elem_reg      <= elem_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    // The search pipe is empty whenever a new word can be taken.
    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !tag1_reg.valid && !tag2_reg.valid && !tag3_reg.valid)
        else $error("search pipe busy while ready");

    // The walk never addresses a codeword outside the count in use.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SRCH) |-> (code_reg < count_reg) && (32'(elem_reg) < 32'(len_reg)))
        else $error("search address out of range");

    // The chosen codeword lies inside the count in use.
    a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SRCH_OUT) |-> (best_reg < count_reg))
        else $error("best index out of range");

    // An error status always closes its run.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == vq_pkg::STATUS_BAD_INDEX) |-> out_data.last_result)
        else $error("error word without last mark");

    // Each search ends with exactly one result word.
    a_search_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SRCH_OUT) && slot_free |=> out_valid && out_data.last_result
        && (out_data.status == vq_pkg::STATUS_OK))
        else $error("search result missing");

endmodule

`default_nettype wire

[verif/vector_quantizer_nearest_codeword_unit_test.sv]
// Self-checking testbench for the vector quantizer with nearest-codeword search.
`timescale 1ns / 1ps

// Scoreboard: keeps its own codebook, query and registers, and queues the words it expects.
class codeword_scoreboard;
    logic signed [vq_pkg::VALUE_BITS-1:0]
        stored_code [vq_pkg::MAX_CODEWORDS_DEF*vq_pkg::MAX_DIM_DEF];
    logic signed [vq_pkg::VALUE_BITS-1:0] query_elems [vq_pkg::MAX_DIM_DEF];
    int unsigned       count_reg;
    int unsigned       length_reg;
    vq_pkg::out_word_t awaited [$];
    int                mismatches;
    int                checked;

    function new();
        count_reg  = vq_pkg::COUNT_RESET;
        length_reg = vq_pkg::LEN_RESET;
        mismatches = 0;
        checked    = 0;
    endfunction

    function void set_register(logic [vq_pkg::CFG_INDEX_BITS-1:0] idx,
                               logic [vq_pkg::CFG_BITS-1:0] value);
        if (idx == vq_pkg::REG_CODEWORDS_IN_USE)
            count_reg = int'(value);
        else if (idx == vq_pkg::REG_VECTOR_LENGTH)
            length_reg = int'(value[vq_pkg::LEN_BITS-1:0]);
    endfunction

    // Codewords searched; zero acts as one and large values saturate.
    function int searched();
        int n;
        n = count_reg;
        if (n == 0)
            n = 1;
        if (n > vq_pkg::MAX_CODEWORDS_DEF)
            n = vq_pkg::MAX_CODEWORDS_DEF;
        return n;
    endfunction

    function int elements();
        int n;
        n = length_reg;
        if (n == 0)
            n = 1;
        if (n > vq_pkg::MAX_DIM_DEF)
            n = vq_pkg::MAX_DIM_DEF;
        return n;
    endfunction

    // Squared distance to every codeword in use; the first strictly smaller one wins.
    function logic [7:0] nearest_index();
        longint unsigned best_dist;
        longint unsigned dist_sum;
        longint          diff;
        int              best;
        best      = 0;
        best_dist = 0;
        for (int c = 0; c < searched(); c++)
        begin
            dist_sum = 0;
            for (int e = 0; e < elements(); e++)
            begin
                diff = longint'(query_elems[e])
                       - longint'(stored_code[c*vq_pkg::MAX_DIM_DEF + e]);
                dist_sum += longint'(diff * diff);
            end
            if (c == 0 || dist_sum < best_dist)
            begin
                best_dist = dist_sum;
                best      = c;
            end
        end
        return best[7:0];
    endfunction

    function void note_input(vq_pkg::in_word_t w);
        vq_pkg::out_word_t r;
        int                base;
        base = int'(w.code_index) * vq_pkg::MAX_DIM_DEF;
        r    = '0;
        case (w.func)
            vq_pkg::FUNC_WRITE:
                stored_code[base + int'(w.position)] = w.sample;
            vq_pkg::FUNC_ENCODE:
            begin
                query_elems[w.position] = w.sample;
                if (w.final_element)
                begin
                    r.found_index = nearest_index();
                    r.status      = vq_pkg::STATUS_OK;
                    r.last_result = 1'b1;
                    awaited.push_back(r);
                end
            end
            vq_pkg::FUNC_DECODE:
            begin
                r.found_index = w.code_index;
                if (int'(w.code_index) >= searched())
                begin
                    r.status      = vq_pkg::STATUS_BAD_INDEX;
                    r.last_result = 1'b1;
                    awaited.push_back(r);
                end
                else
                begin
                    for (int e = 0; e < elements(); e++)
                    begin
                        r.element_out = stored_code[base + e];
                        r.status      = vq_pkg::STATUS_OK;
                        r.last_result = (e == elements() - 1);
                        awaited.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void report(string field, logic signed [31:0] want, logic signed [31:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endfunction

    function void check_result(vq_pkg::out_word_t got);
        vq_pkg::out_word_t want;
        if (awaited.size() == 0)
        begin
            $display("%0t: unexpected result word, expected none, actual %h", $time, got);
            mismatches++;
            return;
        end
        want = awaited.pop_front();
        checked++;
        if (got.found_index !== want.found_index)
            report("found_index", 32'(want.found_index), 32'(got.found_index));
        if (got.element_out !== want.element_out)
            report("element_out", 32'(want.element_out), 32'(got.element_out));
        if (got.status !== want.status)
            report("status", 32'(want.status), 32'(got.status));
        if (got.last_result !== want.last_result)
            report("last_result", 32'(want.last_result), 32'(got.last_result));
    endfunction
endclass

module vector_quantizer_nearest_codeword_unit_test;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int STUCK_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    // Codewords written in full before any search or readout touches them.
    localparam int PRELOAD_CODES = 8;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_write = 1'b0;
    logic [vq_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [vq_pkg::CFG_BITS-1:0]       cfg_data  = '0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    vq_pkg::in_word_t                  in_data   = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    vq_pkg::out_word_t                 out_data;

    codeword_scoreboard board;
    bit steady      = 1'b0;
    bit hold_output = 1'b0;
    int items_sent  = 0;
    int settings    = 0;

    vector_quantizer_nearest_codeword_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    // Idle length: mostly none, some short, a few long; none in steady stretches.
    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [vq_pkg::VALUE_BITS-1:0] random_sample();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic vq_pkg::in_word_t make_word(logic [1:0] func, logic [7:0] code,
                                                   logic [3:0] pos,
                                                   logic signed [vq_pkg::VALUE_BITS-1:0] value,
                                                   logic fin);
        vq_pkg::in_word_t w;
        w.func          = func;
        w.code_index    = code;
        w.position      = pos;
        w.sample        = value;
        w.final_element = fin;
        return w;
    endfunction

    // Offer one word, hold it until accepted, then idle for a random gap.
    task automatic send_word(input vq_pkg::in_word_t w);
        int gap;
        in_data  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_input(w);
        if (w.func != FUNC_UNUSED)
            items_sent++;
        gap = stall_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    // Registers change only with the block idle.
    task automatic write_register(input logic [vq_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [vq_pkg::CFG_BITS-1:0] value);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_register(idx, value);
        settings++;
    endtask

    // One query vector: near a chosen codeword, random, or at the extremes.
    task automatic send_query();
        int len;
        int target;
        int flavor;
        int value;
        len    = board.elements();
        target = $urandom_range(0, board.searched() - 1);
        flavor = $urandom_range(0, 3);
        for (int e = 0; e < len; e++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_word(make_word(vq_pkg::FUNC_ENCODE, 8'($urandom), 4'($urandom),
                                    random_sample(), 1'b0));
            if (flavor <= 1)
            begin
                value = int'(board.stored_code[target*vq_pkg::MAX_DIM_DEF + e]);
                if (flavor == 1)
                    value = value + int'($urandom_range(0, 16)) - 8;
                if (value > 32767)
                    value = 32767;
                if (value < -32768)
                    value = -32768;
            end
            else if (flavor == 2)
                value = int'(random_sample());
            else
                value = $urandom_range(0, 1) ? 32767 : -32768;
            // Now and then a sequence breaks off before its final element.
            if (e == len - 1 && $urandom_range(0, 9) == 0)
                return;
            send_word(make_word(vq_pkg::FUNC_ENCODE, 8'($urandom), e[3:0], value[15:0],
                                e == len - 1));
        end
    endtask

    // Readout of a preloaded codeword, or of an index past the count in use.
    task automatic send_decode();
        int n;
        int idx;
        n = board.searched();
        if (n < vq_pkg::MAX_CODEWORDS_DEF && $urandom_range(0, 4) == 0)
            idx = $urandom_range(n, vq_pkg::MAX_CODEWORDS_DEF - 1);
        else
            idx = $urandom_range(0, ((n < PRELOAD_CODES) ? n : PRELOAD_CODES) - 1);
        send_word(make_word(vq_pkg::FUNC_DECODE, idx[7:0], 4'($urandom), random_sample(),
                            1'($urandom)));
    endtask

    // One register setting followed by a random mix of sequences.
    task automatic run_phase(input logic [vq_pkg::CFG_BITS-1:0] count_value,
                             input logic [vq_pkg::CFG_BITS-1:0] length_value,
                             input int budget, input bit pressure, input bit calm);
        int start;
        int r;
        bit paused;
        write_register(vq_pkg::REG_CODEWORDS_IN_USE, count_value);
        write_register(vq_pkg::REG_VECTOR_LENGTH, length_value);
        steady      = calm;
        hold_output = pressure;
        start       = items_sent;
        paused      = 1'b0;
        while (items_sent - start < budget)
        begin
            if (!paused && items_sent - start >= budget / 2)
            begin
                wait_all_results();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            // Searches run only while every codeword in use has been preloaded.
            if (r < 55 && board.searched() <= PRELOAD_CODES)
                send_query();
            else if (r < 75)
                send_decode();
            else if (r < 93)
                send_word(make_word(vq_pkg::FUNC_WRITE, 8'($urandom), 4'($urandom),
                                    random_sample(), 1'($urandom)));
            else
                send_word(make_word(FUNC_UNUSED, 8'($urandom), 4'($urandom), 16'($urandom),
                                    1'($urandom)));
        end
        steady = 1'b0;
    endtask

    // Result side: checks accepted words and stalls at random or on request.
    initial
    begin
        int hold;
        hold = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(out_data);
            if (hold_output)
            begin
                hold_output = 1'b0;
                hold        = HOLD_CYCLES;
            end
            if (hold == 0)
                hold = stall_length();
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    initial
    begin
        int stuck;
        stuck = 0;
        wait (rst_n === 1'b1);
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: timeout, no word moved for %0d cycles", $time, stuck);
        $display("Mismatches found");
        $finish;
    end

    // Main sequence.
    initial
    begin
        int preload;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the first codewords and the query buffer so that every later read is defined.
        steady = 1'b1;
        for (int c = 0; c < PRELOAD_CODES; c++)
            for (int e = 0; e < vq_pkg::MAX_DIM_DEF; e++)
                send_word(make_word(vq_pkg::FUNC_WRITE, c[7:0], e[3:0], random_sample(),
                                    1'($urandom)));
        for (int e = 0; e < vq_pkg::MAX_DIM_DEF; e++)
            send_word(make_word(vq_pkg::FUNC_ENCODE, 8'($urandom), e[3:0], random_sample(),
                                1'b0));
        steady  = 1'b0;
        preload = items_sent;

        // Field extremes at the reset setting and an unused code.
        send_word(make_word(vq_pkg::FUNC_WRITE, 8'd255, 4'd15, 16'sh7fff, 1'b0));
        send_word(make_word(vq_pkg::FUNC_WRITE, 8'd255, 4'd0, 16'sh8000, 1'b1));
        send_word(make_word(vq_pkg::FUNC_DECODE, 8'(PRELOAD_CODES - 1), 4'd0, 16'sh0000,
                            1'b0));
        send_word(make_word(vq_pkg::FUNC_DECODE, 8'd0, 4'd15, 16'sh7fff, 1'b1));
        send_word(make_word(FUNC_UNUSED, 8'd255, 4'd15, 16'shffff, 1'b1));

        // A full-length search over every preloaded codeword.
        write_register(vq_pkg::REG_CODEWORDS_IN_USE, 9'(PRELOAD_CODES));
        send_word(make_word(vq_pkg::FUNC_ENCODE, 8'd0, 4'd15, 16'sh7fff, 1'b0));
        send_word(make_word(vq_pkg::FUNC_ENCODE, 8'd255, 4'd0, 16'sh8000, 1'b1));

        // Four one-element codewords, two of them equal, for ties and bad indexes.
        write_register(vq_pkg::REG_CODEWORDS_IN_USE, 9'd4);
        write_register(vq_pkg::REG_VECTOR_LENGTH, 9'd1);
        send_word(make_word(vq_pkg::FUNC_WRITE, 8'd0, 4'd0, 16'sh8000, 1'b0));
        send_word(make_word(vq_pkg::FUNC_WRITE, 8'd1, 4'd0, 16'sd100, 1'b0));
        send_word(make_word(vq_pkg::FUNC_WRITE, 8'd2, 4'd0, 16'sh7fff, 1'b0));
        send_word(make_word(vq_pkg::FUNC_WRITE, 8'd3, 4'd0, 16'sd100, 1'b0));
        send_word(make_word(vq_pkg::FUNC_ENCODE, 8'd0, 4'd0, 16'sd100, 1'b1));
        send_word(make_word(vq_pkg::FUNC_ENCODE, 8'd0, 4'd0, 16'sh8000, 1'b1));
        send_word(make_word(vq_pkg::FUNC_ENCODE, 8'd0, 4'd0, 16'sh7fff, 1'b1));
        send_word(make_word(vq_pkg::FUNC_DECODE, 8'd4, 4'd0, 16'sh0000, 1'b0));
        send_word(make_word(vq_pkg::FUNC_DECODE, 8'd3, 4'd0, 16'sh0000, 1'b0));
        send_word(make_word(vq_pkg::FUNC_DECODE, 8'd255, 4'd0, 16'sh0000, 1'b0));

        // Random phases: reset setting, smallest, zero values, oversized values, then mixed.
        run_phase(9'd256, 9'd16, 15, 1'b0, 1'b0);
        run_phase(9'd1, 9'd1, 15, 1'b0, 1'b1);
        run_phase(9'd0, 9'h1e0, 10, 1'b0, 1'b0);
        run_phase(9'h1ff, 9'h1ff, 10, 1'b0, 1'b0);
        for (int p = 0; p < 4; p++)
            run_phase(9'($urandom_range(2, PRELOAD_CODES)),
                      9'(($urandom_range(0, 15) << 5) | $urandom_range(1, 16)),
                      18, p == 0, 1'b0);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d result words from %0d input words after a %0d word preload.",
                 board.checked, items_sent - preload, preload);
        $display("Covered %0d register writes, ties, bad decode indexes and full-length searches.",
                 settings);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/vq_pkg.sv
rtl/vector_quantizer_nearest_codeword_unit.sv
verif/vector_quantizer_nearest_codeword_unit_test.sv
